### src/lcd_mode_timing_controller_assert.svh
// ---------------------------------------------------------------------------
// LCD timing controller assertion macros
// Shared property wrappers for the checker of the LCD timing controller.
// ---------------------------------------------------------------------------
`ifndef LCD_MODE_TIMING_CONTROLLER_ASSERT_SVH
`define LCD_MODE_TIMING_CONTROLLER_ASSERT_SVH

// Property that is checked only outside of reset.
`define LCDT_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lcdt assertion failed");

// Property that is also checked while reset is high.
`define LCDT_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("lcdt reset assertion failed");

`endif

### src/lcdt_pkg.sv
// ---------------------------------------------------------------------------
// LCD timing controller package
// Types, register offsets and reset values shared by the controller files.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcdt_pkg;

  // Item kinds carried on the input channel.
  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_IDLE  = 2'd3
  } action_t;

  // Display phases, encoded as the status mode bits.
  typedef enum logic [1:0] {
    PH_HBLANK = 2'd0,
    PH_VBLANK = 2'd1,
    PH_OAM    = 2'd2,
    PH_VRAM   = 2'd3
  } phase_t;

  // Register offsets within the display register window.
  localparam logic [3:0] REG_CONTROL      = 4'd0;
  localparam logic [3:0] REG_STATUS       = 4'd1;
  localparam logic [3:0] REG_SCROLL_Y     = 4'd2;
  localparam logic [3:0] REG_SCROLL_X     = 4'd3;
  localparam logic [3:0] REG_LINE_COUNT   = 4'd4;
  localparam logic [3:0] REG_LINE_COMPARE = 4'd5;
  localparam logic [3:0] REG_BG_PALETTE   = 4'd7;
  localparam logic [3:0] REG_OBJ_PALETTE0 = 4'd8;
  localparam logic [3:0] REG_OBJ_PALETTE1 = 4'd9;
  localparam logic [3:0] REG_WINDOW_Y     = 4'd10;
  localparam logic [3:0] REG_WINDOW_X     = 4'd11;

  // Bit positions in the control and status registers.
  localparam int CTRL_DISPLAY_ON = 7;
  localparam int STAT_MATCH      = 2;
  localparam int STAT_HBLANK_IE  = 3;
  localparam int STAT_VBLANK_IE  = 4;
  localparam int STAT_OAM_IE     = 5;
  localparam int STAT_MATCH_IE   = 6;
  localparam int STAT_READ_ONE   = 7;

  // Reset values.
  localparam logic [7:0] CONTROL_RESET = 8'h91;
  localparam logic [7:0] STATUS_RESET  = 8'h85;
  localparam logic [7:0] BGP_RESET     = 8'hFC;
  localparam logic [7:0] OBP_RESET     = 8'hFF;
  localparam logic [7:0] UNMAPPED_READ = 8'hFF;

  // The phase clock saturates at its full scale.
  localparam logic [9:0] CLOCK_MAX = 10'h3FF;

  // Outcome of one tick, handed from the timing unit to the top level.
  typedef struct packed {
    logic [9:0] clock;
    logic [7:0] line;
    phase_t     phase;
    logic [7:0] status;
    logic       render;
    logic       vblank;
    logic       stat;
  } tick_res_t;

endpackage

### src/lcdt_timing.sv
// ---------------------------------------------------------------------------
// LCD timing unit
// Combinational phase sequencer: advances the phase clock by one tick and
// makes at most one phase change, updating line counter and status bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcdt_timing
  import lcdt_pkg::*;
#(
  parameter int OAM_CYCLES    = 80,
  parameter int VRAM_CYCLES   = 172,
  parameter int HBLANK_CYCLES = 204,
  parameter int LINE_CYCLES   = 456,
  parameter int VISIBLE_LINES = 144,
  parameter int TOTAL_LINES   = 154
) (
  input  logic [9:0] phase_clock,
  input  phase_t     phase,
  input  logic [7:0] line_count,
  input  logic [7:0] line_compare,
  input  logic [7:0] status,
  input  logic [7:0] cycles,
  output tick_res_t  res
);

  localparam logic [9:0] OAM_LEN    = 10'(OAM_CYCLES);
  localparam logic [9:0] VRAM_LEN   = 10'(VRAM_CYCLES);
  localparam logic [9:0] HBLANK_LEN = 10'(HBLANK_CYCLES);
  localparam logic [9:0] LINE_LEN   = 10'(LINE_CYCLES);
  localparam logic [7:0] VIS_LINES  = 8'(VISIBLE_LINES);
  localparam logic [7:0] ALL_LINES  = 8'(TOTAL_LINES);

  logic [10:0] sum;
  logic [9:0]  clock_sat;
  logic [7:0]  line_inc;
  logic        match;

  always_comb begin
    // Saturating add of the elapsed cycles.
    sum       = {1'b0, phase_clock} + {3'b000, cycles};
    clock_sat = sum[10] ? CLOCK_MAX : sum[9:0];
    line_inc  = line_count + 8'd1;
    match     = 1'b0;

    res        = '0;
    res.clock  = clock_sat;
    res.line   = line_count;
    res.phase  = phase;
    res.status = status;

    // One phase step per tick.
    case (phase)
      PH_OAM: begin
        if (clock_sat >= OAM_LEN) begin
          res.clock            = clock_sat - OAM_LEN;
          res.phase            = PH_VRAM;
          res.status[1:0]      = PH_VRAM;
        end
      end
      PH_VRAM: begin
        if (clock_sat >= VRAM_LEN) begin
          res.clock            = clock_sat - VRAM_LEN;
          res.render           = 1'b1;
          res.phase            = PH_HBLANK;
          res.status[1:0]      = PH_HBLANK;
          res.stat             = status[STAT_HBLANK_IE];
        end
      end
      PH_HBLANK: begin
        if (clock_sat >= HBLANK_LEN) begin
          res.clock                = clock_sat - HBLANK_LEN;
          res.line                 = line_inc;
          match                    = (line_inc == line_compare);
          res.status[STAT_MATCH]   = match;
          if (line_inc >= VIS_LINES) begin
            res.phase       = PH_VBLANK;
            res.status[1:0] = PH_VBLANK;
            res.vblank      = 1'b1;
            res.stat        = (match && status[STAT_MATCH_IE]) || status[STAT_VBLANK_IE];
          end else begin
            res.phase       = PH_OAM;
            res.status[1:0] = PH_OAM;
            res.stat        = (match && status[STAT_MATCH_IE]) || status[STAT_OAM_IE];
          end
        end
      end
      default: begin
        // Vertical blank: whole lines until the frame wraps.
        if (clock_sat >= LINE_LEN) begin
          res.clock = clock_sat - LINE_LEN;
          if (line_inc >= ALL_LINES) begin
            res.line        = 8'd0;
            res.phase       = PH_OAM;
            res.status[1:0] = PH_OAM;
          end else begin
            res.line        = line_inc;
          end
          match                  = (res.line == line_compare);
          res.status[STAT_MATCH] = match;
          res.stat = (match && status[STAT_MATCH_IE]) ||
                     ((line_inc >= ALL_LINES) && status[STAT_OAM_IE]);
        end
      end
    endcase
  end

endmodule

### src/lcd_mode_timing_controller.sv
// Pipeline: a transaction accepted into the input register moves on to the
// result register when that register is empty or being taken (out_ready).
// Throughput: one transaction per cycle while out_ready holds; the input and
// result registers are each refilled in the cycle they empty.
// Reset: rst is synchronous; it empties both registers and loads the display
// registers, line counter, phase clock and phase with their reset values.
// ---------------------------------------------------------------------------
// LCD mode timing controller
// Display register file and mode timing, one transaction per cycle unless stalled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcd_mode_timing_controller
  import lcdt_pkg::*;
#(
  parameter int OAM_CYCLES    = 80,
  parameter int VRAM_CYCLES   = 172,
  parameter int HBLANK_CYCLES = 204,
  parameter int LINE_CYCLES   = 456,
  parameter int VISIBLE_LINES = 144,
  parameter int TOTAL_LINES   = 154
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  logic [7:0] cycles,
  input  logic [3:0] reg_offset,
  input  logic [7:0] write_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic       vblank_raise,
  output logic       stat_raise,
  output logic       render_line,
  output logic [7:0] line,
  output logic [1:0] phase
);

  // Input register.
  logic       item_valid;
  action_t    item_action;
  logic [7:0] item_cycles;
  logic [3:0] item_offset;
  logic [7:0] item_value;
  logic       advance;

  // Architectural state.
  logic [7:0] control, control_next;
  logic [7:0] status, status_next;
  logic [7:0] scroll_y, scroll_y_next;
  logic [7:0] scroll_x, scroll_x_next;
  logic [7:0] line_count, line_count_next;
  logic [7:0] line_compare, line_compare_next;
  logic [7:0] bg_palette, bg_palette_next;
  logic [7:0] obj_palette0, obj_palette0_next;
  logic [7:0] obj_palette1, obj_palette1_next;
  logic [7:0] window_y, window_y_next;
  logic [7:0] window_x, window_x_next;
  logic [9:0] phase_clock, phase_clock_next;
  phase_t     phase_reg, phase_reg_next;

  // Per-transaction results.
  logic [7:0] rd_next;
  logic       vb_next;
  logic       stat_next;
  logic       rl_next;
  logic       match;
  tick_res_t  tick;

  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      item_action <= action_t'(action);
      item_cycles <= cycles;
      item_offset <= reg_offset;
      item_value  <= write_value;
    end
  end

  // Phase sequencer for ticks.
  lcdt_timing #(
    .OAM_CYCLES    (OAM_CYCLES),
    .VRAM_CYCLES   (VRAM_CYCLES),
    .HBLANK_CYCLES (HBLANK_CYCLES),
    .LINE_CYCLES   (LINE_CYCLES),
    .VISIBLE_LINES (VISIBLE_LINES),
    .TOTAL_LINES   (TOTAL_LINES)
  ) u_timing (
    .phase_clock  (phase_clock),
    .phase        (phase_reg),
    .line_count   (line_count),
    .line_compare (line_compare),
    .status       (status),
    .cycles       (item_cycles),
    .res          (tick)
  );

  // Next state and results for the transaction in the input register.
  always_comb begin
    control_next      = control;
    status_next       = status;
    scroll_y_next     = scroll_y;
    scroll_x_next     = scroll_x;
    line_count_next   = line_count;
    line_compare_next = line_compare;
    bg_palette_next   = bg_palette;
    obj_palette0_next = obj_palette0;
    obj_palette1_next = obj_palette1;
    window_y_next     = window_y;
    window_x_next     = window_x;
    phase_clock_next  = phase_clock;
    phase_reg_next    = phase_reg;
    rd_next           = 8'd0;
    vb_next           = 1'b0;
    stat_next         = 1'b0;
    rl_next           = 1'b0;
    match             = (line_count == item_value);

    case (item_action)
      ACT_TICK: begin
        if (control[CTRL_DISPLAY_ON]) begin
          phase_clock_next = tick.clock;
          line_count_next  = tick.line;
          phase_reg_next   = tick.phase;
          status_next      = tick.status;
          rl_next          = tick.render;
          vb_next          = tick.vblank;
          stat_next        = tick.stat;
        end
      end
      ACT_READ: begin
        case (item_offset)
          REG_CONTROL:      rd_next = control;
          REG_STATUS:       rd_next = status | (8'd1 << STAT_READ_ONE);
          REG_SCROLL_Y:     rd_next = scroll_y;
          REG_SCROLL_X:     rd_next = scroll_x;
          REG_LINE_COUNT:   rd_next = line_count;
          REG_LINE_COMPARE: rd_next = line_compare;
          REG_BG_PALETTE:   rd_next = bg_palette;
          REG_OBJ_PALETTE0: rd_next = obj_palette0;
          REG_OBJ_PALETTE1: rd_next = obj_palette1;
          REG_WINDOW_Y:     rd_next = window_y;
          REG_WINDOW_X:     rd_next = window_x;
          default:          rd_next = UNMAPPED_READ;
        endcase
      end
      ACT_WRITE: begin
        case (item_offset)
          REG_CONTROL: begin
            // Turning the display off parks the timing in horizontal blank.
            if (control[CTRL_DISPLAY_ON] && !item_value[CTRL_DISPLAY_ON]) begin
              line_count_next  = 8'd0;
              phase_clock_next = 10'd0;
              phase_reg_next   = PH_HBLANK;
              status_next[1:0] = PH_HBLANK;
            end
            control_next = item_value;
          end
          REG_STATUS: begin
            status_next = {status[7], item_value[6:3], status[2:0]};
          end
          REG_SCROLL_Y:     scroll_y_next = item_value;
          REG_SCROLL_X:     scroll_x_next = item_value;
          REG_LINE_COMPARE: begin
            line_compare_next       = item_value;
            status_next[STAT_MATCH] = match;
            stat_next               = match && status[STAT_MATCH_IE];
          end
          REG_BG_PALETTE:   bg_palette_next = item_value;
          REG_OBJ_PALETTE0: obj_palette0_next = item_value;
          REG_OBJ_PALETTE1: obj_palette1_next = item_value;
          REG_WINDOW_Y:     window_y_next = item_value;
          REG_WINDOW_X:     window_x_next = item_value;
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // State registers, updated once per processed transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      control      <= CONTROL_RESET;
      status       <= STATUS_RESET;
      scroll_y     <= 8'd0;
      scroll_x     <= 8'd0;
      line_count   <= 8'd0;
      line_compare <= 8'd0;
      bg_palette   <= BGP_RESET;
      obj_palette0 <= OBP_RESET;
      obj_palette1 <= OBP_RESET;
      window_y     <= 8'd0;
      window_x     <= 8'd0;
      phase_clock  <= 10'd0;
      phase_reg    <= PH_OAM;
    end else if (advance) begin
      control      <= control_next;
      status       <= status_next;
      scroll_y     <= scroll_y_next;
      scroll_x     <= scroll_x_next;
      line_count   <= line_count_next;
      line_compare <= line_compare_next;
      bg_palette   <= bg_palette_next;
      obj_palette0 <= obj_palette0_next;
      obj_palette1 <= obj_palette1_next;
      window_y     <= window_y_next;
      window_x     <= window_x_next;
      phase_clock  <= phase_clock_next;
      phase_reg    <= phase_reg_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      read_data    <= rd_next;
      vblank_raise <= vb_next;
      stat_raise   <= stat_next;
      render_line  <= rl_next;
      line         <= line_count_next;
      phase        <= phase_reg_next;
    end
  end

endmodule

### src/lcdt_checker.sv
// ---------------------------------------------------------------------------
// LCD timing controller checker
// Port-level properties of the controller, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "lcd_mode_timing_controller_assert.svh"

module lcdt_checker
  import lcdt_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] read_data,
  input logic       vblank_raise,
  input logic       render_line,
  input logic [1:0] phase
);

  // A stalled result keeps its payload.
  `LCDT_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(phase))

  // Reset empties the result register.
  `LCDT_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)

  // Entering vertical blank leaves the phase at vertical blank.
  `LCDT_ASSERT(a_vblank_phase, clk, rst, out_valid && vblank_raise |-> phase == PH_VBLANK)

  // The end of the transfer phase lands in horizontal blank, with no read data.
  `LCDT_ASSERT(a_render_phase, clk, rst, out_valid && render_line |-> phase == PH_HBLANK && read_data == 8'd0 && !vblank_raise)

endmodule

bind lcd_mode_timing_controller lcdt_checker u_checker (.*);

### tb/sv/lcd_mode_timing_controller_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LCD mode timing controller testbench
// Sends ticks, register reads and register writes through the input channel
// and tracks the display registers, line counter and phase in a local model.
// Each result is checked field by field against the model's expectation,
// with random idle gaps and output stalls on both channels.
// ---------------------------------------------------------------------------

module lcd_mode_timing_controller_tb;
  import lcdt_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int OAM_LEN        = 80;
  localparam int VRAM_LEN       = 172;
  localparam int HBLANK_LEN     = 204;
  localparam int LINE_LEN       = 456;
  localparam int VISIBLE_LINES  = 144;
  localparam int TOTAL_LINES    = 154;
  localparam int RANDOM_ITEMS   = 1075;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int DRAIN_CYCLES   = 8;

  // Offsets with no register behind them.
  localparam logic [3:0] REG_UNUSED   = 4'd6;
  localparam logic [3:0] REG_SPARE_LO = 4'd12;
  localparam logic [3:0] REG_SPARE_HI = 4'd15;

  typedef struct {
    action_t    act;
    logic [7:0] cyc;
    logic [3:0] offset;
    logic [7:0] value;
    bit         hold;
  } bus_item_t;

  typedef struct {
    logic [7:0] read_data;
    logic       vblank;
    logic       stat;
    logic       render;
    logic [7:0] line;
    phase_t     phase;
  } lcd_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  action_t    action = ACT_TICK;
  logic [7:0] cycles = 8'd0;
  logic [3:0] reg_offset = 4'd0;
  logic [7:0] write_value = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] read_data;
  logic       vblank_raise;
  logic       stat_raise;
  logic       render_line;
  logic [7:0] line;
  logic [1:0] phase;

  bus_item_t   bus_items[$];
  lcd_result_t lcd_results_due[$];

  int mismatches = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int send_calm = 0;
  int recv_stall = 0;
  int recv_calm = 0;

  // Local copy of the display state.
  logic [7:0] ctrl_r, stat_r, scroll_y_r, scroll_x_r, ly_r, lyc_r;
  logic [7:0] bgp_r, obp0_r, obp1_r, win_y_r, win_x_r;
  logic [9:0] dot_clock;
  phase_t     cur_phase;
  logic       stat_hit;

  lcd_mode_timing_controller DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .cycles       (cycles),
    .reg_offset   (reg_offset),
    .write_value  (write_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .vblank_raise (vblank_raise),
    .stat_raise   (stat_raise),
    .render_line  (render_line),
    .line         (line),
    .phase        (phase)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Display state after reset.
  function automatic void reset_display_state();
    ctrl_r     = CONTROL_RESET;
    stat_r     = STATUS_RESET;
    scroll_y_r = 8'd0;
    scroll_x_r = 8'd0;
    ly_r       = 8'd0;
    lyc_r      = 8'd0;
    bgp_r      = BGP_RESET;
    obp0_r     = OBP_RESET;
    obp1_r     = OBP_RESET;
    win_y_r    = 8'd0;
    win_x_r    = 8'd0;
    dot_clock  = 10'd0;
    cur_phase  = PH_OAM;
  endfunction

  // A phase change updates the mode bits and may raise the stat request.
  function automatic void set_phase(phase_t p);
    cur_phase = p;
    stat_r[1:0] = p;
    if ((p == PH_HBLANK && stat_r[STAT_HBLANK_IE]) ||
        (p == PH_VBLANK && stat_r[STAT_VBLANK_IE]) ||
        (p == PH_OAM && stat_r[STAT_OAM_IE]))
      stat_hit = 1'b1;
  endfunction

  // Line compare coincidence flag and its interrupt.
  function automatic void check_coincidence();
    if (ly_r == lyc_r) begin
      stat_r[STAT_MATCH] = 1'b1;
      if (stat_r[STAT_MATCH_IE])
        stat_hit = 1'b1;
    end else begin
      stat_r[STAT_MATCH] = 1'b0;
    end
  endfunction

  // Applies one transaction to the local state and returns its result.
  function automatic lcd_result_t apply_bus_item(bus_item_t it);
    lcd_result_t res;
    int          clk_sum;
    res = '{read_data: 8'd0, vblank: 1'b0, stat: 1'b0, render: 1'b0,
            line: 8'd0, phase: PH_HBLANK};
    stat_hit = 1'b0;
    case (it.act)
      ACT_TICK: begin
        if (ctrl_r[CTRL_DISPLAY_ON]) begin
          clk_sum = int'(dot_clock) + int'(it.cyc);
          if (clk_sum > int'(CLOCK_MAX))
            clk_sum = int'(CLOCK_MAX);
          case (cur_phase)
            PH_OAM: begin
              if (clk_sum >= OAM_LEN) begin
                clk_sum -= OAM_LEN;
                set_phase(PH_VRAM);
              end
            end
            PH_VRAM: begin
              if (clk_sum >= VRAM_LEN) begin
                clk_sum -= VRAM_LEN;
                res.render = 1'b1;
                set_phase(PH_HBLANK);
              end
            end
            PH_HBLANK: begin
              if (clk_sum >= HBLANK_LEN) begin
                clk_sum -= HBLANK_LEN;
                ly_r = ly_r + 8'd1;
                check_coincidence();
                if (ly_r >= VISIBLE_LINES) begin
                  set_phase(PH_VBLANK);
                  res.vblank = 1'b1;
                end else begin
                  set_phase(PH_OAM);
                end
              end
            end
            default: begin
              if (clk_sum >= LINE_LEN) begin
                clk_sum -= LINE_LEN;
                ly_r = ly_r + 8'd1;
                if (ly_r >= TOTAL_LINES) begin
                  ly_r = 8'd0;
                  set_phase(PH_OAM);
                end
                check_coincidence();
              end
            end
          endcase
          dot_clock = clk_sum[9:0];
        end
      end
      ACT_READ: begin
        case (it.offset)
          REG_CONTROL:      res.read_data = ctrl_r;
          REG_STATUS:       res.read_data = stat_r | (8'd1 << STAT_READ_ONE);
          REG_SCROLL_Y:     res.read_data = scroll_y_r;
          REG_SCROLL_X:     res.read_data = scroll_x_r;
          REG_LINE_COUNT:   res.read_data = ly_r;
          REG_LINE_COMPARE: res.read_data = lyc_r;
          REG_BG_PALETTE:   res.read_data = bgp_r;
          REG_OBJ_PALETTE0: res.read_data = obp0_r;
          REG_OBJ_PALETTE1: res.read_data = obp1_r;
          REG_WINDOW_Y:     res.read_data = win_y_r;
          REG_WINDOW_X:     res.read_data = win_x_r;
          default:          res.read_data = UNMAPPED_READ;
        endcase
      end
      ACT_WRITE: begin
        case (it.offset)
          REG_CONTROL: begin
            // Turning the display off restarts the line at HBLANK, silently.
            if (ctrl_r[CTRL_DISPLAY_ON] && !it.value[CTRL_DISPLAY_ON]) begin
              ly_r = 8'd0;
              dot_clock = 10'd0;
              cur_phase = PH_HBLANK;
              stat_r[1:0] = PH_HBLANK;
            end
            ctrl_r = it.value;
          end
          REG_STATUS:       stat_r = (stat_r & 8'h87) | (it.value & 8'h78);
          REG_SCROLL_Y:     scroll_y_r = it.value;
          REG_SCROLL_X:     scroll_x_r = it.value;
          REG_LINE_COMPARE: begin
            lyc_r = it.value;
            check_coincidence();
          end
          REG_BG_PALETTE:   bgp_r = it.value;
          REG_OBJ_PALETTE0: obp0_r = it.value;
          REG_OBJ_PALETTE1: obp1_r = it.value;
          REG_WINDOW_Y:     win_y_r = it.value;
          REG_WINDOW_X:     win_x_r = it.value;
          default: ;
        endcase
      end
      default: ;
    endcase
    res.stat  = stat_hit;
    res.line  = ly_r;
    res.phase = cur_phase;
    return res;
  endfunction

  // Idle length for either side: mostly none or short, a few long, and
  // now and then a calm stretch with no idling at all.
  function automatic int pick_idle(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bus_item_t make_item(action_t act, logic [7:0] cyc,
                                          logic [3:0] offset, logic [7:0] value);
    bus_item_t it;
    it.act    = act;
    it.cyc    = cyc;
    it.offset = offset;
    it.value  = value;
    it.hold   = 1'b0;
    return it;
  endfunction

  // Random transaction, weighted toward ticks so that frames run through.
  function automatic bus_item_t random_bus_item();
    bus_item_t it;
    int        r;
    it = make_item(ACT_TICK, 8'($urandom), 4'($urandom), 8'($urandom));
    r = $urandom_range(0, 99);
    if (r < 70) begin
      it.act = ACT_TICK;
      if ($urandom_range(0, 3) != 0)
        it.cyc = 8'($urandom_range(120, 255));
    end else if (r < 82) begin
      it.act = ACT_READ;
    end else if (r < 98) begin
      it.act = ACT_WRITE;
      case ($urandom_range(0, 9))
        0: begin
          it.offset = REG_CONTROL;
          // The display is switched off only rarely.
          it.value[CTRL_DISPLAY_ON] = ($urandom_range(0, 29) != 0);
        end
        1, 2: it.offset = REG_STATUS;
        3, 4: begin
          it.offset = REG_LINE_COMPARE;
          if ($urandom_range(0, 3) != 0)
            it.value = 8'($urandom_range(0, TOTAL_LINES - 1));
        end
        5: begin
          case ($urandom_range(0, 2))
            0: it.offset = REG_LINE_COUNT;
            1: it.offset = REG_UNUSED;
            default: it.offset = 4'($urandom_range(REG_SPARE_LO, REG_SPARE_HI));
          endcase
        end
        default: begin
          case ($urandom_range(0, 6))
            0: it.offset = REG_SCROLL_Y;
            1: it.offset = REG_SCROLL_X;
            2: it.offset = REG_BG_PALETTE;
            3: it.offset = REG_OBJ_PALETTE0;
            4: it.offset = REG_OBJ_PALETTE1;
            5: it.offset = REG_WINDOW_Y;
            default: it.offset = REG_WINDOW_X;
          endcase
        end
      endcase
    end else begin
      it.act = ACT_IDLE;
    end
    return it;
  endfunction

  // Driver: presents queued transactions and predicts each one on acceptance.
  always @(posedge clk) begin
    bus_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      reset_display_state();
    end else begin
      if (in_valid && in_ready)
        lcd_results_due.push_back(apply_bus_item(make_item(action, cycles,
                                                           reg_offset, write_value)));
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (bus_items.size() != 0 &&
                     !(bus_items[0].hold && lcd_results_due.size() != 0)) begin
          nxt = bus_items.pop_front();
          action      <= nxt.act;
          cycles      <= nxt.cyc;
          reg_offset  <= nxt.offset;
          write_value <= nxt.value;
          in_valid    <= 1'b1;
          send_gap = pick_idle(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction against the oldest expectation.
  always @(posedge clk) begin
    lcd_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (lcd_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: rd=%h vb=%b st=%b rl=%b line=%0d phase=%0d",
                     read_data, vblank_raise, stat_raise, render_line, line, phase);
        end else begin
          want = lcd_results_due.pop_front();
          if (read_data !== want.read_data || vblank_raise !== want.vblank ||
              stat_raise !== want.stat || render_line !== want.render ||
              line !== want.line || phase !== want.phase) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch: exp rd=%h vb=%b st=%b rl=%b line=%0d phase=%0d, got rd=%h vb=%b st=%b rl=%b line=%0d phase=%0d",
                       want.read_data, want.vblank, want.stat, want.render,
                       want.line, want.phase, read_data, vblank_raise,
                       stat_raise, render_line, line, phase);
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_stall = pick_idle(recv_calm);
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and end of run.
  initial begin
    bus_item_t it;
    // Reads of every offset in the reset state.
    for (int off = 0; off < 16; off++)
      bus_items.push_back(make_item(ACT_READ, 8'h00, 4'(off), 8'h00));
    // Smallest and largest ticks, and the idle action.
    bus_items.push_back(make_item(ACT_TICK, 8'h00, REG_CONTROL, 8'hFF));
    bus_items.push_back(make_item(ACT_TICK, 8'hFF, REG_SPARE_HI, 8'h00));
    bus_items.push_back(make_item(ACT_IDLE, 8'hFF, REG_STATUS, 8'hFF));
    // All status enables on, then a line compare match that raises stat.
    bus_items.push_back(make_item(ACT_WRITE, 8'h00, REG_STATUS, 8'hFF));
    bus_items.push_back(make_item(ACT_WRITE, 8'hFF, REG_LINE_COMPARE, 8'h00));
    // Display off after a full drain, a tick while off, then back on.
    it = make_item(ACT_WRITE, 8'h00, REG_CONTROL, 8'h00);
    it.hold = 1'b1;
    bus_items.push_back(it);
    bus_items.push_back(make_item(ACT_TICK, 8'hFF, REG_CONTROL, 8'h00));
    bus_items.push_back(make_item(ACT_WRITE, 8'h00, REG_CONTROL, 8'hFF));
    // Write to the read-only line counter is dropped.
    bus_items.push_back(make_item(ACT_WRITE, 8'h00, REG_LINE_COUNT, 8'hAB));
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      it = random_bus_item();
      if (n % 250 == 0)
        it.hold = 1'b1;
      bus_items.push_back(it);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (bus_items.size() != 0 || in_valid || lcd_results_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/lcdt_pkg.sv
src/lcdt_timing.sv
src/lcd_mode_timing_controller.sv
src/lcdt_checker.sv
tb/sv/lcd_mode_timing_controller_tb.sv
